// File: design/pid_filtered_derivative_antiwindup_top_assert.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent checks sampled on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef PID_FILTERED_DERIVATIVE_ANTIWINDUP_TOP_ASSERT_SVH
`define PID_FILTERED_DERIVATIVE_ANTIWINDUP_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define PIDFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define PIDFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pidfd_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, reset defaults, clamp states, multiplier operation codes and word types.
// ----------------------------------------------------------------------------
package pidfd_pkg;

  localparam int ACC_WIDTH = 32;
  localparam int GAIN_W    = 16;
  localparam int ANG_W     = 16;
  localparam int LIM_W     = 8;
  localparam int DRV_W     = 9;
  localparam int CS_W      = 2;
  localparam int IDX_W     = 3;

  localparam int OPA_W  = GAIN_W + 1;
  localparam int OPB_W  = (ACC_WIDTH > 34) ? ACC_WIDTH : 34;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int SUM_W  = (ACC_WIDTH + 2 > 38) ? ACC_WIDTH + 2 : 38;

  localparam logic [CS_W-1:0] CS_NONE = 2'd0;
  localparam logic [CS_W-1:0] CS_HIGH = 2'd1;
  localparam logic [CS_W-1:0] CS_LOW  = 2'd2;

  localparam logic [IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_INT_STEP = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_DECAY   = 3'd2;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN    = 3'd3;
  localparam logic [IDX_W-1:0] REG_WEIGHT_PROP   = 3'd4;
  localparam logic [IDX_W-1:0] REG_WEIGHT_DERIV  = 3'd5;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd6;

  localparam logic signed [GAIN_W-1:0] RST_GAIN_PROP     = 16'sd1280;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_INT_STEP = 16'sd3277;
  localparam logic signed [GAIN_W-1:0] RST_DERIV_DECAY   = 16'sd32440;
  localparam logic signed [GAIN_W-1:0] RST_DERIV_GAIN    = -16'sd128;
  localparam logic signed [GAIN_W-1:0] RST_WEIGHT_PROP   = 16'sd256;
  localparam logic signed [GAIN_W-1:0] RST_WEIGHT_DERIV  = 16'sd256;
  localparam logic [LIM_W-1:0]         RST_DRIVE_LIMIT   = 8'd245;

  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_INT   = 3'd1;
  localparam logic [2:0] MUL_WP    = 3'd2;
  localparam logic [2:0] MUL_WD    = 3'd3;
  localparam logic [2:0] MUL_KP    = 3'd4;
  localparam logic [2:0] MUL_KD    = 3'd5;
  localparam logic [2:0] MUL_DECAY = 3'd6;

  typedef struct packed {
    logic signed [ANG_W-1:0] setpoint;
    logic signed [ANG_W-1:0] setpoint_prev;
    logic signed [ANG_W-1:0] angle_now;
    logic signed [ANG_W-1:0] angle_prev;
  } in_word_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic [CS_W-1:0]         clamp_state;
  } out_word_t;

  typedef struct packed {
    logic       capture;
    logic [2:0] mul_op;
    logic       ld_ipart;
    logic       ld_opnd_p;
    logic       ld_opnd_d;
    logic       ld_p;
    logic       ld_d;
    logic       merge;
    logic       finish;
  } cmd_t;

endpackage

// File: design/pidfd_datapath.sv
// ----------------------------------------------------------------------------
// PID controller datapath
// Configuration registers, one shared multiplier, term accumulators,
// clamping and the controller state (integral, derivative, saturation).
// ----------------------------------------------------------------------------
module pidfd_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [pidfd_pkg::IDX_W-1:0] cfg_index,
  input  logic [15:0]                cfg_data,
  input  pidfd_pkg::in_word_t        in_data,
  input  pidfd_pkg::cmd_t            cmd,
  output pidfd_pkg::out_word_t       out_data
);
  import pidfd_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF11 = PROD_W'(1024);
  localparam logic signed [PROD_W-1:0] HALF12 = PROD_W'(2048);
  localparam logic signed [PROD_W-1:0] HALF15 = PROD_W'(16384);
  localparam logic signed [SUM_W-1:0]  HALF8  = SUM_W'(128);

  localparam logic signed [ACC_WIDTH:0] I_HI =
    {2'b00, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH:0] I_LO =
    {2'b11, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] D_HI =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] D_LO =
    {{(SUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

  logic signed [GAIN_W-1:0] gain_prop, gain_int_step, deriv_decay, deriv_gain;
  logic signed [GAIN_W-1:0] weight_prop, weight_deriv;
  logic [LIM_W-1:0]         drive_limit;

  logic signed [ACC_WIDTH-1:0] integral_acc, deriv_acc;
  logic [CS_W-1:0]             sat_dir;

  in_word_t                  in_reg;
  logic signed [ANG_W:0]     e_int, sp_diff, ang_diff;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [OPB_W-1:0]   opnd;
  logic signed [PROD_W-1:0]  rnd11, rnd12, rnd15;

  logic signed [ACC_WIDTH-1:0] di, ipart, ipart_next, int_sat;
  logic signed [ACC_WIDTH:0]   int_sum;
  logic                        hold;

  logic signed [SUM_W-1:0] psum, dsum, d_raw, d_sat;
  logic signed [SUM_W-1:0] total, lim_s, neg_lim, rounded;
  logic signed [DRV_W-1:0] drive_next;
  logic [CS_W-1:0]         cs_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop     <= RST_GAIN_PROP;
      gain_int_step <= RST_GAIN_INT_STEP;
      deriv_decay   <= RST_DERIV_DECAY;
      deriv_gain    <= RST_DERIV_GAIN;
      weight_prop   <= RST_WEIGHT_PROP;
      weight_deriv  <= RST_WEIGHT_DERIV;
      drive_limit   <= RST_DRIVE_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_PROP:     gain_prop     <= cfg_data;
        REG_GAIN_INT_STEP: gain_int_step <= cfg_data;
        REG_DERIV_DECAY:   deriv_decay   <= cfg_data;
        REG_DERIV_GAIN:    deriv_gain    <= cfg_data;
        REG_WEIGHT_PROP:   weight_prop   <= cfg_data;
        REG_WEIGHT_DERIV:  weight_deriv  <= cfg_data;
        REG_DRIVE_LIMIT:   drive_limit   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign e_int    = (ANG_W+1)'(in_reg.setpoint_prev) - (ANG_W+1)'(in_reg.angle_prev);
  assign sp_diff  = (ANG_W+1)'(in_reg.setpoint) - (ANG_W+1)'(in_reg.setpoint_prev);
  assign ang_diff = (ANG_W+1)'(in_reg.angle_now) - (ANG_W+1)'(in_reg.angle_prev);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mul_op)
      MUL_INT: begin
        op_a = OPA_W'(gain_int_step);
        op_b = OPB_W'(e_int);
      end
      MUL_WP: begin
        op_a = OPA_W'(weight_prop);
        op_b = OPB_W'(in_reg.setpoint);
      end
      MUL_WD: begin
        op_a = OPA_W'(weight_deriv);
        op_b = OPB_W'(sp_diff);
      end
      MUL_KP: begin
        op_a = OPA_W'(gain_prop);
        op_b = opnd;
      end
      MUL_KD: begin
        op_a = OPA_W'(deriv_gain);
        op_b = opnd;
      end
      MUL_DECAY: begin
        op_a = OPA_W'(deriv_decay);
        op_b = OPB_W'(deriv_acc);
      end
      default: ;
    endcase
  end

  assign rnd11 = (prod + HALF11) >>> 11;
  assign rnd12 = (prod + HALF12) >>> 12;
  assign rnd15 = (prod + HALF15) >>> 15;

  // integral increment with anti-windup hold
  assign di      = ACC_WIDTH'(rnd11);
  assign int_sum = (ACC_WIDTH+1)'(integral_acc) + (ACC_WIDTH+1)'(di);
  assign hold    = ((sat_dir == CS_HIGH) && !di[ACC_WIDTH-1] && (di != '0)) ||
                   ((sat_dir == CS_LOW) && di[ACC_WIDTH-1]);

  always_comb begin
    if (int_sum > I_HI) begin
      int_sat = I_HI[ACC_WIDTH-1:0];
    end else if (int_sum < I_LO) begin
      int_sat = I_LO[ACC_WIDTH-1:0];
    end else begin
      int_sat = int_sum[ACC_WIDTH-1:0];
    end
    ipart_next = hold ? integral_acc : int_sat;
  end

  assign d_raw = dsum + SUM_W'(rnd15);

  always_comb begin
    if (d_raw > D_HI) begin
      d_sat = D_HI;
    end else if (d_raw < D_LO) begin
      d_sat = D_LO;
    end else begin
      d_sat = d_raw;
    end
  end

  // clamp to the drive limit
  assign total   = psum + dsum;
  assign lim_s   = {{(SUM_W-LIM_W-8){1'b0}}, drive_limit, 8'b0};
  assign neg_lim = -lim_s;
  assign rounded = (total + HALF8) >>> 8;

  always_comb begin
    if (total > lim_s) begin
      drive_next = {1'b0, drive_limit};
      cs_next    = CS_HIGH;
    end else if (total < neg_lim) begin
      drive_next = -{1'b0, drive_limit};
      cs_next    = CS_LOW;
    end else begin
      drive_next = rounded[DRV_W-1:0];
      cs_next    = CS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_reg <= in_data;
    end
    prod <= PROD_W'(op_a * op_b);
    if (cmd.ld_ipart) begin
      ipart <= ipart_next;
    end
    if (cmd.ld_opnd_p) begin
      opnd <= OPB_W'(prod) - (OPB_W'(in_reg.angle_now) <<< 8);
    end
    if (cmd.ld_opnd_d) begin
      opnd <= OPB_W'(prod) - (OPB_W'(ang_diff) <<< 8);
    end
    if (cmd.ld_p) begin
      psum <= SUM_W'(rnd12);
    end
    if (cmd.ld_d) begin
      dsum <= SUM_W'(rnd12);
    end
    if (cmd.merge) begin
      dsum <= d_sat;
      psum <= psum + SUM_W'(ipart);
    end
    if (cmd.finish) begin
      out_data.drive       <= drive_next;
      out_data.clamp_state <= cs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      deriv_acc    <= '0;
      sat_dir      <= CS_NONE;
    end else if (cmd.finish) begin
      deriv_acc <= dsum[ACC_WIDTH-1:0];
      sat_dir   <= cs_next;
      if (cs_next == CS_NONE) begin
        integral_acc <= ipart;
      end
    end
  end

endmodule

// File: design/pidfd_ctrl.sv
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps the datapath through its multiplications and owns the handshakes.
// ----------------------------------------------------------------------------
`include "pid_filtered_derivative_antiwindup_top_assert.svh"

module pidfd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output pidfd_pkg::cmd_t cmd
);
  import pidfd_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INT   = 4'd1;
  localparam logic [3:0] ST_WP    = 4'd2;
  localparam logic [3:0] ST_PDIFF = 4'd3;
  localparam logic [3:0] ST_PMUL  = 4'd4;
  localparam logic [3:0] ST_DMUL  = 4'd5;
  localparam logic [3:0] ST_DECAY = 4'd6;
  localparam logic [3:0] ST_MERGE = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0] state, state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_INT;
        end
      end
      ST_INT: begin
        cmd.mul_op = MUL_INT;
        state_next = ST_WP;
      end
      ST_WP: begin
        cmd.ld_ipart = 1'b1;
        cmd.mul_op   = MUL_WP;
        state_next   = ST_PDIFF;
      end
      ST_PDIFF: begin
        cmd.ld_opnd_p = 1'b1;
        cmd.mul_op    = MUL_WD;
        state_next    = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.ld_opnd_d = 1'b1;
        cmd.mul_op    = MUL_KP;
        state_next    = ST_DMUL;
      end
      ST_DMUL: begin
        cmd.ld_p   = 1'b1;
        cmd.mul_op = MUL_KD;
        state_next = ST_DECAY;
      end
      ST_DECAY: begin
        cmd.ld_d   = 1'b1;
        cmd.mul_op = MUL_DECAY;
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PIDFD_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == ST_INT, "accept did not start")
  `PIDFD_ASSERT_NOW(a_finish_free, cmd.finish, !out_valid || !out_stall, "result overwritten")
  `PIDFD_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid && state == ST_IDLE, "result not shown")
  `PIDFD_ASSERT_NOW(a_one_load, 1'b1, $onehot0({cmd.ld_ipart, cmd.ld_opnd_p, cmd.ld_opnd_d, cmd.ld_p, cmd.ld_d, cmd.merge, cmd.finish}), "load clash")

endmodule

// File: design/pid_filtered_derivative_antiwindup_top.sv
// ----------------------------------------------------------------------------
// PID controller with filtered derivative and clamping anti-windup
// Input word: setpoint, previous setpoint, angle, previous angle (Q12.4).
// Output word: clamped drive and clamp state.
// Usage:
//   Words enter on in_valid / in_stall and leave on out_valid / out_stall;
//   a word moves on an edge with valid high and stall low.
//   Gains and the limit are written through cfg_we / cfg_index / cfg_data
//   while no word is in flight; writes to unused indexes are dropped.
//   An accepted word steps through the six products, which share one
//   multiplier in turn, then through the merge and clamp steps; no new word
//   is accepted until the clamp step of the last one has finished.
//   A finished word waits in the output register while the next word is
//   accepted and processed; if it is still stalled when the next result is
//   ready, the sequencer holds in its last step until it is taken.
//   Reset returns every gain and the limit to its default, clears the
//   integral and derivative state and the saturation flag, and empties
//   the output register.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_antiwindup_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pidfd_pkg::IDX_W-1:0] cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pidfd_pkg::in_word_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pidfd_pkg::out_word_t        out_data
);
  import pidfd_pkg::*;

  cmd_t cmd;

  pidfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pidfd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// File: dv/tb_pid_filtered_derivative_antiwindup_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives setpoint and angle words through the controller under a run of gain
// and limit settings, predicts every drive word and clamp state in a
// scoreboard with its own integral, derivative and saturation state, and
// compares each result in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pid_filtered_derivative_antiwindup_top;
  import pidfd_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {
    SET_DEFAULT, SET_MODERATE, SET_MAX, SET_MIN, SET_WILD, SET_MIXED, SET_NARROW
  } setting_e;

  class pid_drive_board;
    longint    kp, kit, decay, kd, wp, wd, lim;
    longint    integ, deriv;
    logic [1:0] sat;
    out_word_t drive_due_q[$];
    int        mismatches, checked, n_high, n_low, n_lin;

    function new();
      kp = RST_GAIN_PROP;
      kit = RST_GAIN_INT_STEP;
      decay = RST_DERIV_DECAY;
      kd = RST_DERIV_GAIN;
      wp = RST_WEIGHT_PROP;
      wd = RST_WEIGHT_DERIV;
      lim = RST_DRIVE_LIMIT;
      integ = 0;
      deriv = 0;
      sat = CS_NONE;
      mismatches = 0;
      checked = 0;
      n_high = 0;
      n_low = 0;
      n_lin = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [15:0] d);
      case (idx)
        REG_GAIN_PROP:     kp = $signed(d);
        REG_GAIN_INT_STEP: kit = $signed(d);
        REG_DERIV_DECAY:   decay = $signed(d);
        REG_DERIV_GAIN:    kd = $signed(d);
        REG_WEIGHT_PROP:   wp = $signed(d);
        REG_WEIGHT_DERIV:  wd = $signed(d);
        REG_DRIVE_LIMIT:   lim = d[7:0];
        default: ;
      endcase
    endfunction

    function longint clip_acc(longint x);
      longint hi, lo;
      hi = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    function longint round_down(longint x, int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function void note_word(in_word_t w);
      longint sp, spp, ang, angp, di, ip, pp, dp, sum, lv;
      out_word_t e;
      sp = $signed(w.setpoint);
      spp = $signed(w.setpoint_prev);
      ang = $signed(w.angle_now);
      angp = $signed(w.angle_prev);
      di = clip_acc(round_down(kit * (spp - angp), 11));
      if ((sat == CS_HIGH && di > 0) || (sat == CS_LOW && di < 0)) ip = integ;
      else ip = clip_acc(integ + di);
      pp = round_down(kp * (wp * sp - ang * 256), 12);
      dp = clip_acc(round_down(decay * deriv, 15)
                    + round_down(kd * (wd * (sp - spp) - (ang - angp) * 256), 12));
      sum = pp + ip + dp;
      lv = lim * 256;
      if (sum > lv) begin
        e.drive = lim[8:0];
        e.clamp_state = CS_HIGH;
        sat = CS_HIGH;
      end else if (sum < -lv) begin
        e.drive = 9'(-lim);
        e.clamp_state = CS_LOW;
        sat = CS_LOW;
      end else begin
        e.drive = 9'(round_down(sum, 8));
        e.clamp_state = CS_NONE;
        sat = CS_NONE;
        integ = ip;
      end
      deriv = dp;
      drive_due_q.push_back(e);
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (drive_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected drive word: drive %0d clamp %0d",
                   got.drive, got.clamp_state);
        return;
      end
      e = drive_due_q.pop_front();
      checked++;
      case (e.clamp_state)
        CS_HIGH: n_high++;
        CS_LOW:  n_low++;
        default: n_lin++;
      endcase
      if (got.drive !== e.drive || got.clamp_state !== e.clamp_state) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: drive %0d clamp %0d, expected drive %0d clamp %0d",
                   checked, got.drive, got.clamp_state, e.drive, e.clamp_state);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_data;

  pid_drive_board board;
  logic calm;
  int   trk_sp, trk_ang, sent, settings;

  pid_filtered_derivative_antiwindup_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_word(out_data);
    out_stall <= !calm && ($urandom_range(99) < 12);
  end

  task automatic send_word(input in_word_t w);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(w);
    sent++;
  endtask

  task automatic send_fields(input int sp, input int spp, input int ang, input int angp);
    in_word_t w;
    w.setpoint = 16'(sp);
    w.setpoint_prev = 16'(spp);
    w.angle_now = 16'(ang);
    w.angle_prev = 16'(angp);
    send_word(w);
  endtask

  // hold the sender until every result is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.drive_due_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    board.set_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] p, input logic [15:0] i, input logic [15:0] dc,
                           input logic [15:0] kd, input logic [15:0] b, input logic [15:0] c,
                           input logic [7:0] l);
    write_reg(REG_GAIN_PROP, p);
    write_reg(REG_GAIN_INT_STEP, i);
    write_reg(REG_DERIV_DECAY, dc);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_WEIGHT_PROP, b);
    write_reg(REG_WEIGHT_DERIV, c);
    write_reg(REG_DRIVE_LIMIT, {8'd0, l});
    settings++;
  endtask

  task automatic apply_setting(input setting_e s);
    int t;
    settle();
    case (s)
      SET_DEFAULT:
        load_regs(RST_GAIN_PROP, RST_GAIN_INT_STEP, RST_DERIV_DECAY, RST_DERIV_GAIN,
                  RST_WEIGHT_PROP, RST_WEIGHT_DERIV, RST_DRIVE_LIMIT);
      SET_MAX:
        load_regs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd255);
      SET_MIN:
        load_regs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'd0);
      SET_MODERATE: begin
        t = $urandom_range(1024);
        t = t - 512;
        load_regs(16'($urandom_range(2048)), 16'($urandom_range(8000)),
                  16'(20000 + $urandom_range(12767)), 16'(t),
                  16'($urandom_range(512)), 16'($urandom_range(512)),
                  8'($urandom_range(255)));
      end
      SET_WILD:
        load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 8'($urandom));
      SET_MIXED:
        load_regs(16'd256, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd0, 16'h8000, 8'd255);
      default:
        load_regs(16'd256, 16'h7FFF, 16'd0, 16'd256, 16'd256, 16'd256, 8'd1);
    endcase
  endtask

  task automatic make_word(output in_word_t w);
    int r, sp_n, ang_n;
    r = $urandom_range(99);
    if (r < 70) begin
      sp_n = trk_sp;
      if ($urandom_range(9) == 0) begin
        sp_n = $urandom_range(4000);
        sp_n = sp_n - 2000;
      end
      ang_n = $urandom_range(32);
      ang_n = trk_ang + (sp_n - trk_ang) / 4 + ang_n - 16;
      w.setpoint = 16'(sp_n);
      w.setpoint_prev = 16'(trk_sp);
      w.angle_now = 16'(ang_n);
      w.angle_prev = 16'(trk_ang);
      trk_sp = sp_n;
      trk_ang = ang_n;
    end else if (r < 85) begin
      ang_n = $urandom_range(64);
      w.setpoint = 16'(trk_sp);
      w.setpoint_prev = 16'($urandom_range(8000) - 4000);
      w.angle_now = 16'(trk_ang + ang_n - 32);
      w.angle_prev = 16'($urandom_range(8000) - 4000);
    end else begin
      w = {$urandom, $urandom};
    end
  endtask

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    setting_e plan [9];
    in_word_t w;
    clk = 1'b0;
    board = new();
    calm = 1'b0;
    trk_sp = 0;
    trk_ang = 0;
    sent = 0;
    settings = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_GAIN_PROP;
    cfg_data <= 16'd0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero limit: only a zero sum stays linear
    write_reg(REG_DRIVE_LIMIT, 16'd0);
    send_fields(0, 0, 0, 0);
    send_fields(160, 160, 0, 0);
    settle();
    write_reg(REG_DRIVE_LIMIT, {8'd0, RST_DRIVE_LIMIT});
    write_reg(REG_UNUSED, 16'hFFFF);

    repeat (3) send_fields(160, 160, 0, 0);
    repeat (2) send_fields(-160, -160, 0, 0);
    repeat (2) send_fields(32767, 32767, -32768, -32768);
    send_fields(32767, -32768, -32768, 32767);
    repeat (2) send_fields(-32768, -32768, 32767, 32767);
    send_fields(-32768, 32767, 32767, -32768);
    send_fields(32767, 32767, 32767, 32767);
    send_fields(-32768, -32768, -32768, -32768);
    send_fields(32767, -32768, 32767, -32768);
    send_fields(-32768, 32767, -32768, 32767);
    repeat (2) send_fields(0, 0, 0, 0);
    send_fields(16, 0, 0, 16);

    plan = '{SET_DEFAULT, SET_MODERATE, SET_MAX, SET_MODERATE, SET_MIN,
             SET_WILD, SET_MIXED, SET_NARROW, SET_MODERATE};
    foreach (plan[k]) begin
      apply_setting(plan[k]);
      calm = (k == 1);
      for (int n = 0; n < 115; n++) begin
        if (n == 60) calm = 1'b0;
        if (n == 57) settle();
        make_word(w);
        send_word(w);
      end
    end
    calm = 1'b0;
    settle();
    repeat (20) @(posedge clk);

    $display("Covered %0d words across %0d register settings", sent, settings);
    $display("Results: %0d linear, %0d clamped high, %0d clamped low",
             board.n_lin, board.n_high, board.n_low);
    if (board.mismatches == 0 && board.drive_due_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
